/* design/i2c_master_bit_engine_assert.svh */
// Assertion helpers for the I2C bit engine.
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// same-cycle implication, reset masked
`define I2CM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/i2cm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    localparam logic [4:0] PHASE_IDLE   = 5'd31;
    localparam logic [4:0] STEPS_START  = 5'd3;
    localparam logic [4:0] STEPS_STOP   = 5'd4;
    localparam logic [4:0] STEPS_WRITE  = 5'd19;
    localparam logic [4:0] STEPS_READ   = 5'd20;
    localparam logic [4:0] PH_BITS_END  = 5'd16;
    localparam logic [4:0] PH_ACK_A     = 5'd16;
    localparam logic [4:0] PH_ACK_B     = 5'd17;
    localparam logic [4:0] PH_ACK_C     = 5'd18;

    localparam logic [15:0] HALF_PERIOD_RST = 16'd10;

    typedef struct packed {
        logic scl;
        logic sda;
    } pins_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] wr_data;
        logic       rd_ack;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic [15:0] delay;
        logic [4:0]  phase;
        logic [7:0]  shift;
        logic [2:0]  op;
        logic        ack_choice;
        pins_t       pins;
        logic        ack_err;
        logic [7:0]  held_rd;
    } seq_state_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rd_byte;
        logic       ack_error;
    } result_t;

    localparam seq_state_t SEQ_STATE_RST = '{
        delay:      16'd0,
        phase:      PHASE_IDLE,
        shift:      8'd0,
        op:         OP_TICK,
        ack_choice: 1'b0,
        pins:       '{scl: 1'b1, sda: 1'b1},
        ack_err:    1'b0,
        held_rd:    8'd0
    };

    function automatic logic [4:0] step_count(input logic [2:0] op);
        logic [4:0] n;
        case (op)
            OP_START: n = STEPS_START;
            OP_STOP:  n = STEPS_STOP;
            OP_WRITE: n = STEPS_WRITE;
            default:  n = STEPS_READ;
        endcase
        return n;
    endfunction

    // pin levels set when step s of op begins
    function automatic pins_t apply_step(input logic [2:0] op, input logic [4:0] s,
                                         input logic [7:0] shift, input logic ack,
                                         input pins_t pins_in);
        pins_t p;
        p = pins_in;
        case (op)
            OP_START:
            begin
                if (s == 5'd0)
                begin
                    p.scl = 1'b1;
                    p.sda = 1'b1;
                end
                else if (s == 5'd1)
                    p.sda = 1'b0;
                else
                    p.scl = 1'b0;
            end
            OP_STOP:
            begin
                if (s == 5'd0)
                    p.scl = 1'b0;
                else if (s == 5'd1)
                    p.sda = 1'b0;
                else if (s == 5'd2)
                    p.scl = 1'b1;
                else
                    p.sda = 1'b1;
            end
            OP_WRITE:
            begin
                if (s < PH_BITS_END)
                begin
                    if (!s[0])
                    begin
                        if (s != 5'd0)
                            p.scl = 1'b0;
                        p.sda = shift[7];
                    end
                    else
                        p.scl = 1'b1;
                end
                else if (s == PH_ACK_A)
                begin
                    p.scl = 1'b0;
                    p.sda = 1'b1;
                end
                else if (s == PH_ACK_B)
                    p.scl = 1'b1;
                else
                    p.scl = 1'b0;
            end
            default:
            begin
                if (s < PH_BITS_END)
                    p.scl = ~s[0];
                else if (s == PH_ACK_A)
                    p.scl = 1'b0;
                else if (s == PH_ACK_B)
                    p.sda = ~ack;
                else if (s == PH_ACK_C)
                    p.scl = 1'b1;
                else
                begin
                    p.scl = 1'b0;
                    p.sda = 1'b1;
                end
            end
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

/* design/i2cm_in_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module i2cm_in_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire i2cm_pkg::item_t in_item,
    input  wire logic          take,
    output logic               stage_valid,
    output i2cm_pkg::item_t    stage_item
);
    import i2cm_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready    = !valid_reg || take;
    assign valid_next  = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_item;
    end

endmodule

`default_nettype wire

/* design/i2cm_step.sv */
`timescale 1ns / 1ps
`default_nettype none

module i2cm_step (
    input  wire i2cm_pkg::seq_state_t st,
    input  wire i2cm_pkg::item_t      item,
    input  wire logic [15:0]          half_period,
    output i2cm_pkg::seq_state_t      st_next,
    output i2cm_pkg::result_t         res
);
    import i2cm_pkg::*;

    logic        start;
    logic [15:0] hold;
    logic [15:0] dec;
    logic [4:0]  phase_inc;
    logic        busy;
    logic        done;
    seq_state_t  a;
    seq_state_t  nx;

    always_comb
    begin
        start = (st.phase == PHASE_IDLE) && (item.cmd >= OP_START) && (item.cmd <= OP_READ);
        hold  = (half_period == 16'd0) ? 16'd1 : half_period;

        // launch a new command: first step applies on this same tick
        a = st;
        if (start)
        begin
            a.op         = item.cmd;
            a.phase      = 5'd0;
            a.shift      = (item.cmd == OP_WRITE) ? item.wr_data : 8'd0;
            a.ack_choice = item.rd_ack;
            a.pins       = apply_step(item.cmd, 5'd0, a.shift, item.rd_ack, st.pins);
            a.delay      = hold;
        end

        nx        = a;
        busy      = 1'b0;
        done      = 1'b0;
        dec       = a.delay - 16'd1;
        phase_inc = a.phase + 5'd1;

        if (a.phase != PHASE_IDLE)
        begin
            busy     = 1'b1;
            nx.delay = dec;
            if (dec == 16'd0)
            begin
                // end of step: sample SDA on the last tick of SCL high
                if (a.op == OP_WRITE)
                begin
                    if (a.phase < PH_BITS_END && a.phase[0])
                        nx.shift = {a.shift[6:0], 1'b0};
                    else if (a.phase == PH_ACK_B)
                        nx.ack_err = item.sda_in;
                end
                else if (a.op == OP_READ)
                begin
                    if (a.phase < PH_BITS_END && !a.phase[0])
                        nx.shift = {a.shift[6:0], item.sda_in};
                end

                nx.phase = phase_inc;
                if (phase_inc >= step_count(a.op))
                begin
                    done     = 1'b1;
                    nx.phase = PHASE_IDLE;
                    if (a.op == OP_READ)
                        nx.held_rd = nx.shift;
                end
                else
                begin
                    nx.pins  = apply_step(a.op, phase_inc, nx.shift, a.ack_choice, a.pins);
                    nx.delay = hold;
                end
            end
        end

        st_next       = nx;
        res.scl_level = nx.pins.scl;
        res.sda_level = nx.pins.sda;
        res.busy_res  = busy;
        res.done_res  = done;
        res.rd_byte   = nx.held_rd;
        res.ack_error = nx.ack_err;
    end

endmodule

`default_nettype wire

/* design/i2c_master_bit_engine.sv */
// I2C master bit engine: drives SCL and open-drain SDA, one request per bus tick.
// Request channel (in_valid/in_ready): cmd, wr_data, rd_ack, sda_in. Each request
// is one tick; a command (start, stop, write byte, read byte) is taken only when
// the sequencer is idle, otherwise it is ignored and the tick just advances timing.
// Result channel (out_valid/out_ready): one result per request carrying the pin
// drives, busy_res, the done_res pulse, the held rd_byte and ack_error.
// Config channel (cfg_valid/cfg_ready/cfg_data): half_period, always ready; write it
// only while no request is in flight. A zero value behaves as one.
// The request passes from the input register through the step logic into the result
// register, and out_valid rises when it lands there.
// Throughput: one request per cycle while results are taken; the sequencer update is a
// single pass of step logic between those two registers.
// A stalled result holds in the result register; the input register keeps taking a
// request per cycle while the result is taken, and in_ready drops only when both
// are full and out_ready is low.
// Reset: sequencer idle with pins released high and held rd_byte and ack_error zero,
// half_period 10, no result pending; the result register itself is not reset.
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_master_bit_engine_assert.svh"

module i2c_master_bit_engine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  cmd,
    input  wire logic [7:0]  wr_data,
    input  wire logic        rd_ack,
    input  wire logic        sda_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             scl_level,
    output logic             sda_level,
    output logic             busy_res,
    output logic             done_res,
    output logic [7:0]       rd_byte,
    output logic             ack_error
);
    import i2cm_pkg::*;

    logic [15:0] hp_reg;
    item_t       in_item;
    item_t       stage_item;
    logic        stage_valid;
    logic        take;
    logic        advance;
    seq_state_t  state_reg;
    seq_state_t  state_next;
    result_t     res_next;
    result_t     res_reg;
    logic        out_valid_reg;
    logic        out_valid_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hp_reg <= HALF_PERIOD_RST;
        else if (cfg_valid && cfg_ready)
            hp_reg <= cfg_data;
    end

    assign in_item = '{cmd: cmd, wr_data: wr_data, rd_ack: rd_ack, sda_in: sda_in};

    assign take    = !out_valid_reg || out_ready;
    assign advance = stage_valid && take;

    i2cm_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .take        (take),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    i2cm_step u_step (
        .st          (state_reg),
        .item        (stage_item),
        .half_period (hp_reg),
        .st_next     (state_next),
        .res         (res_next)
    );

    assign out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_STATE_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign scl_level = res_reg.scl_level;
    assign sda_level = res_reg.sda_level;
    assign busy_res  = res_reg.busy_res;
    assign done_res  = res_reg.done_res;
    assign rd_byte   = res_reg.rd_byte;
    assign ack_error = res_reg.ack_error;

    `I2CM_ASSERT_NOW(a_done_is_busy, out_valid && done_res, busy_res,
        "done reported without busy")
    `I2CM_ASSERT_NOW(a_running_delay, state_reg.phase != PHASE_IDLE, state_reg.delay != 16'd0,
        "running step with zero delay")
    `I2CM_ASSERT_NOW(a_phase_range, state_reg.phase != PHASE_IDLE, state_reg.phase < STEPS_READ,
        "phase beyond last step")
    `I2CM_ASSERT_NEXT(a_done_to_idle, advance && res_next.done_res,
        state_reg.phase == PHASE_IDLE, "sequencer not idle after done")

endmodule

`default_nettype wire
